[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RCPB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("rcpb assertion failed");

// An implication whose consequent is checked in the cycle after the antecedent.
`define RCPB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    `RCPB_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

[rtl/rcpb_pkg.sv]
package rcpb_pkg;

    localparam int NumCh          = 8;
    localparam int ChIdxW         = 3;
    localparam int CfgIdxW        = 4;
    localparam int ValW           = 16;
    localparam int CodeW          = 12;
    localparam int ByteW          = 8;
    localparam int PktLen         = 13;
    localparam int PosW           = 4;
    localparam int HopW           = 5;
    localparam int PhaseW         = 5;
    localparam int XW             = 15;
    localparam int RecipW         = 23;
    localparam int ProdW          = XW + RecipW;
    localparam int RecipShift     = 25;

    localparam int HopCountDef    = 20;
    localparam int FsPeriodDef    = 17;

    localparam logic [ByteW-1:0]  IdStick    = 8'h57;
    localparam logic [ByteW-1:0]  IdFailsafe = 8'hac;
    localparam logic [CodeW-1:0]  CodeMax    = CodeW'((1 << CodeW) - 1);
    localparam logic signed [16:0] ChOffset  = 17'sd10000;
    localparam logic signed [16:0] ChSpan    = 17'sd20000;
    // floor(x * 4096 / 20000) equals (x * RecipMul) >> RecipShift for x below 20000.
    localparam logic [RecipW-1:0] RecipMul   = 23'd6871948;

    typedef logic [CodeW-1:0] code_t;
    typedef logic [NumCh-1:0][CodeW-1:0] code_vec_t;
    typedef logic signed [ValW-1:0] val_t;

    typedef struct packed {
        logic            failsafe;
        logic [HopW-1:0] hop;
    } pkt_meta_t;

endpackage

[rtl/rcpb_lane.sv]
module rcpb_lane (
    input  logic                 aclk,
    input  logic                 en_x,
    input  logic                 en_code,
    input  rcpb_pkg::val_t       value_in,
    output rcpb_pkg::code_t      code_out
);
    import rcpb_pkg::*;

    logic signed [16:0] sum;
    logic               neg;
    logic               over;
    logic               neg_reg;
    logic               over_reg;
    logic [XW-1:0]      x_reg;
    logic [ProdW-1:0]   prod;
    code_t              code_next;
    code_t              code_reg;

    always_comb begin
        sum  = {value_in[ValW-1], value_in} + ChOffset;
        neg  = sum[16];
        over = !neg && (sum >= ChSpan);
    end

    always_ff @(posedge aclk) begin
        if (en_x) begin
            neg_reg  <= neg;
            over_reg <= over;
            x_reg    <= sum[XW-1:0];
        end
    end

    always_comb begin
        prod = ProdW'(x_reg) * ProdW'(RecipMul);
        if (neg_reg) begin
            code_next = '0;
        end else if (over_reg) begin
            code_next = CodeMax;
        end else begin
            code_next = prod[RecipShift +: CodeW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_code) begin
            code_reg <= code_next;
        end
    end

    assign code_out = code_reg;

endmodule

[rtl/rcpb_merge.sv]
module rcpb_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load_valid,
    output logic                          load_ready,
    input  rcpb_pkg::code_vec_t           codes,
    input  rcpb_pkg::pkt_meta_t           meta,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rcpb_pkg::ByteW-1:0]    m_packet_byte,
    output logic [rcpb_pkg::PosW-1:0]     m_byte_position,
    output logic                          m_last_byte,
    output logic [rcpb_pkg::HopW-1:0]     m_hop_slot,
    output logic                          m_failsafe_frame
);
    import rcpb_pkg::*;

    logic [ByteW-1:0] pkt_reg [PktLen];
    logic [ByteW-1:0] pkt_next [PktLen];
    pkt_meta_t        meta_reg;
    logic [PosW-1:0]  pos_reg;
    logic [PosW-1:0]  pos_next;
    logic             busy_reg;
    logic             busy_next;
    logic             last;
    logic             load;

    assign last       = (pos_reg == PosW'(PktLen - 1));
    assign load_ready = !busy_reg || (m_ready && last);
    assign load       = load_valid && load_ready;

    always_comb begin
        pkt_next[0] = meta.failsafe ? IdFailsafe : IdStick;
        for (int i = 0; i < NumCh; i++) begin
            pkt_next[1 + i] = codes[i][ByteW-1:0];
        end
        for (int k = 0; k < NumCh / 2; k++) begin
            pkt_next[1 + NumCh + k] = {codes[2*k+1][CodeW-1:ByteW],
                                       codes[2*k][CodeW-1:ByteW]};
        end
    end

    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load) begin
            busy_next = 1'b1;
            pos_next  = '0;
        end else if (busy_reg && m_ready) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pkt_reg  <= pkt_next;
            meta_reg <= meta;
        end
    end

    assign m_valid          = busy_reg;
    assign m_packet_byte    = pkt_reg[pos_reg];
    assign m_byte_position  = pos_reg;
    assign m_last_byte      = last;
    assign m_hop_slot       = meta_reg.hop;
    assign m_failsafe_frame = meta_reg.failsafe;

endmodule

[rtl/rc_stick_packet_builder_core.sv]
// Builds one 13-byte stick or failsafe packet per transfer of eight channel values.
// Each input transfer advances the hop index and the failsafe phase; the packet
// bytes then leave one per cycle while m_ready is high, through the single byte
// output. Eight lanes convert the channels in parallel through a two-stage offset,
// clamp and reciprocal-multiply path; an input is registered in val_reg, x_reg,
// code_reg and the merge packet register before its first byte appears. The next
// item is taken while the current packet is still being sent.
module rc_stick_packet_builder_core #(
    parameter int HOP_COUNT       = rcpb_pkg::HopCountDef,
    parameter int FAILSAFE_PERIOD = rcpb_pkg::FsPeriodDef
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rcpb_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rcpb_pkg::ValW-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_live_ch1,
    input  logic signed [15:0]            s_live_ch2,
    input  logic signed [15:0]            s_live_ch3,
    input  logic signed [15:0]            s_live_ch4,
    input  logic signed [15:0]            s_live_ch5,
    input  logic signed [15:0]            s_live_ch6,
    input  logic signed [15:0]            s_live_ch7,
    input  logic signed [15:0]            s_live_ch8,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_packet_byte,
    output logic [3:0]                    m_byte_position,
    output logic                          m_last_byte,
    output logic [4:0]                    m_hop_slot,
    output logic                          m_failsafe_frame
);
    import rcpb_pkg::*;

    val_t            live [NumCh];
    val_t            fs_val_reg [NumCh];
    val_t            val_reg [NumCh];
    logic [HopW-1:0]   hop_reg;
    logic [HopW-1:0]   hop_next;
    logic [PhaseW-1:0] phase_reg;
    logic [PhaseW-1:0] phase_next;
    logic            fs_now;
    pkt_meta_t       s0_meta_reg;
    pkt_meta_t       s1_meta_reg;
    pkt_meta_t       s2_meta_reg;
    logic            s0_valid_reg;
    logic            s1_valid_reg;
    logic            s2_valid_reg;
    logic            s0_ready;
    logic            s1_ready;
    logic            s2_ready;
    logic            s_fire;
    logic            en_x;
    logic            en_code;
    logic            pk_ready;
    logic            pk_load;
    code_vec_t       codes;

    assign live[0] = s_live_ch1;
    assign live[1] = s_live_ch2;
    assign live[2] = s_live_ch3;
    assign live[3] = s_live_ch4;
    assign live[4] = s_live_ch5;
    assign live[5] = s_live_ch6;
    assign live[6] = s_live_ch7;
    assign live[7] = s_live_ch8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumCh; i++) begin
                fs_val_reg[i] <= '0;
            end
        end else if (cfg_wr_en && (cfg_index < CfgIdxW'(NumCh))) begin
            fs_val_reg[cfg_index[ChIdxW-1:0]] <= cfg_wdata;
        end
    end

    assign s2_ready = !s2_valid_reg || pk_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign s_ready  = s0_ready;
    assign s_fire   = s_valid && s0_ready;
    assign en_x     = s0_valid_reg && s1_ready;
    assign en_code  = s1_valid_reg && s2_ready;
    assign pk_load  = s2_valid_reg;

    always_comb begin
        hop_next   = (hop_reg == HopW'(HOP_COUNT - 1)) ? '0 : hop_reg + 1'b1;
        phase_next = (phase_reg == PhaseW'(FAILSAFE_PERIOD - 1)) ? '0 : phase_reg + 1'b1;
        fs_now     = (phase_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_reg      <= '0;
            phase_reg    <= '0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                hop_reg   <= hop_next;
                phase_reg <= phase_next;
            end
            if (s_fire) begin
                s0_valid_reg <= 1'b1;
            end else if (en_x) begin
                s0_valid_reg <= 1'b0;
            end
            if (en_x) begin
                s1_valid_reg <= 1'b1;
            end else if (en_code) begin
                s1_valid_reg <= 1'b0;
            end
            if (en_code) begin
                s2_valid_reg <= 1'b1;
            end else if (pk_ready) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < NumCh; i++) begin
                val_reg[i] <= fs_now ? fs_val_reg[i] : live[i];
            end
            s0_meta_reg <= '{failsafe: fs_now, hop: hop_next};
        end
        if (en_x) begin
            s1_meta_reg <= s0_meta_reg;
        end
        if (en_code) begin
            s2_meta_reg <= s1_meta_reg;
        end
    end

    for (genvar g = 0; g < NumCh; g++) begin : g_lane
        rcpb_lane u_lane (
            .aclk     (aclk),
            .en_x     (en_x),
            .en_code  (en_code),
            .value_in (val_reg[g]),
            .code_out (codes[g])
        );
    end

    rcpb_merge u_merge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load_valid       (pk_load),
        .load_ready       (pk_ready),
        .codes            (codes),
        .meta             (s2_meta_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_byte    (m_packet_byte),
        .m_byte_position  (m_byte_position),
        .m_last_byte      (m_last_byte),
        .m_hop_slot       (m_hop_slot),
        .m_failsafe_frame (m_failsafe_frame)
    );

endmodule

[rtl/rcpb_checker.sv]
`include "assert_macros.svh"

module rcpb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_packet_byte,
    input logic [3:0] m_byte_position,
    input logic       m_last_byte,
    input logic [4:0] m_hop_slot,
    input logic       m_failsafe_frame
);
    import rcpb_pkg::*;

    `RCPB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_packet_byte) && $stable(m_byte_position))
    `RCPB_ASSERT_NEXT(a_pos_step, aclk, aresetn, m_valid && m_ready && !m_last_byte, m_valid && (m_byte_position == $past(m_byte_position) + 4'd1))
    `RCPB_ASSERT_NEXT(a_frame_const, aclk, aresetn, m_valid && m_ready && !m_last_byte, $stable(m_hop_slot) && $stable(m_failsafe_frame))
    `RCPB_ASSERT(a_last_pos, aclk, aresetn, m_valid |-> (m_last_byte == (m_byte_position == 4'(PktLen - 1))))
    `RCPB_ASSERT(a_id_byte, aclk, aresetn, (m_valid && (m_byte_position == 4'd0)) |-> (m_packet_byte == (m_failsafe_frame ? IdFailsafe : IdStick)))

endmodule

bind rc_stick_packet_builder_core rcpb_checker u_rcpb_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_packet_byte    (m_packet_byte),
    .m_byte_position  (m_byte_position),
    .m_last_byte      (m_last_byte),
    .m_hop_slot       (m_hop_slot),
    .m_failsafe_frame (m_failsafe_frame)
);
